>>> design/tsw_pkg.sv
// ----------------------------------------------------------------------------
// tsw_pkg
// Shared constants and types for the scaled tanh waveshaper.
// ----------------------------------------------------------------------------
package tsw_pkg;

    localparam int SAMPLE_BITS_DEF      = 16;
    localparam int AMOUNT_FRAC_BITS_DEF = 14;

    // Fixed-point format of the ratio datapath (Q0.30).
    localparam int FX_BITS     = 30;
    localparam int CF_DEPTH    = 6;
    localparam int CF_DIV_BITS = 34;
    localparam int G_BITS      = 31;

    typedef enum logic {
        CFG_USE_FIXED    = 1'b0,
        CFG_FIXED_AMOUNT = 1'b1
    } cfg_index_t;

endpackage

>>> design/tsw_sample_if.sv
// ----------------------------------------------------------------------------
// tsw_sample_if
// Input channel: one audio sample and its drive amount per request.
// ----------------------------------------------------------------------------
interface tsw_sample_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int AMOUNT_BITS = 15
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_in;
    logic [AMOUNT_BITS-1:0] amount_in;

    modport source (output valid, output sample_in, output amount_in, input ready);
    modport sink   (input valid, input sample_in, input amount_in, output ready);
endinterface

>>> design/tsw_shaped_if.sv
// ----------------------------------------------------------------------------
// tsw_shaped_if
// Output channel: one shaped sample per request.
// ----------------------------------------------------------------------------
interface tsw_shaped_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] shaped_out;

    modport source (output valid, output shaped_out, input ready);
    modport sink   (input valid, input shaped_out, output ready);
endinterface

>>> design/tsw_cfg_if.sv
// ----------------------------------------------------------------------------
// tsw_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tsw_cfg_if #(
    parameter int DATA_BITS = 15
);
    logic                 valid;
    logic                 ready;
    logic [0:0]           index;
    logic [DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/tsw_front.sv
// ----------------------------------------------------------------------------
// tsw_front
// Configuration registers, amount selection, magnitude, scaled argument
// and its square, in three register stages.
// ----------------------------------------------------------------------------
module tsw_front
    import tsw_pkg::*;
#(
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
    parameter int AMOUNT_FRAC_BITS = AMOUNT_FRAC_BITS_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    tsw_sample_if.sink             samples,
    tsw_cfg_if.sink                cfg,
    output logic                   out_valid,
    output logic [FX_BITS-1:0]     out_w,
    output logic [SAMPLE_BITS-1:0] out_mag,
    output logic                   out_neg
);

    localparam int AW  = AMOUNT_FRAC_BITS + 1;
    localparam int PW  = AW + SAMPLE_BITS;
    localparam int SH  = AMOUNT_FRAC_BITS + SAMPLE_BITS - FX_BITS;
    localparam int LSH = (SH < 0) ? -SH : 0;
    localparam int RSH = (SH > 0) ? SH : 0;
    localparam int XW  = PW + LSH;

    logic                   use_fixed_reg;
    logic [AW-1:0]          fixed_amount_reg;

    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] s1_mag_reg;
    logic                   s1_neg_reg;
    logic [AW-1:0]          s1_amt_reg;

    logic                   s2_valid_reg;
    logic [SAMPLE_BITS-1:0] s2_mag_reg;
    logic                   s2_neg_reg;
    logic [FX_BITS-1:0]     s2_v_reg;

    logic                   s3_valid_reg;
    logic [SAMPLE_BITS-1:0] s3_mag_reg;
    logic                   s3_neg_reg;
    logic [FX_BITS-1:0]     s3_w_reg;

    logic                   in_neg;
    logic [SAMPLE_BITS-1:0] mag_next;
    logic [AW-1:0]          amt_next;
    logic [PW-1:0]          prod;
    logic [XW-1:0]          v_wide;
    logic [FX_BITS-1:0]     v_next;
    logic [2*FX_BITS-1:0]   sq;

    assign samples.ready = en;
    assign cfg.ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_fixed_reg    <= 1'b0;
            fixed_amount_reg <= AW'(1) << AMOUNT_FRAC_BITS;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_USE_FIXED:    use_fixed_reg    <= cfg.data[0];
                CFG_FIXED_AMOUNT: fixed_amount_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    assign in_neg   = samples.sample_in[SAMPLE_BITS-1];
    assign mag_next = in_neg ? (~samples.sample_in + SAMPLE_BITS'(1)) : samples.sample_in;
    assign amt_next = use_fixed_reg ? fixed_amount_reg : samples.amount_in;

    assign prod   = PW'(s1_amt_reg) * PW'(s1_mag_reg);
    assign v_wide = (XW'(prod) << LSH) >> RSH;
    assign v_next = (|(v_wide >> FX_BITS)) ? {FX_BITS{1'b1}} : v_wide[FX_BITS-1:0];

    assign sq = (2*FX_BITS)'(s2_v_reg) * (2*FX_BITS)'(s2_v_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= samples.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mag_reg <= mag_next;
            s1_neg_reg <= in_neg;
            s1_amt_reg <= amt_next;
            s2_mag_reg <= s1_mag_reg;
            s2_neg_reg <= s1_neg_reg;
            s2_v_reg   <= v_next;
            s3_mag_reg <= s2_mag_reg;
            s3_neg_reg <= s2_neg_reg;
            s3_w_reg   <= sq[2*FX_BITS-1:FX_BITS];
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_w     = s3_w_reg;
    assign out_mag   = s3_mag_reg;
    assign out_neg   = s3_neg_reg;

endmodule

>>> design/tsw_div.sv
// ----------------------------------------------------------------------------
// tsw_div
// Pipelined restoring divider, one quotient bit per register stage. The
// dividend's low bits are zero, so only the leading remainder enters.
// ----------------------------------------------------------------------------
module tsw_div #(
    parameter int QBITS  = 30,
    parameter int DIV_W  = 34,
    parameter int SIDE_W = 8
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DIV_W-1:0]  in_rem,
    input  logic [DIV_W-1:0]  in_div,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QBITS-1:0]  out_quot,
    output logic [SIDE_W-1:0] out_side
);

    logic              vld_reg  [QBITS];
    logic [DIV_W-1:0]  rem_reg  [QBITS];
    logic [DIV_W-1:0]  div_reg  [QBITS];
    logic [QBITS-1:0]  quot_reg [QBITS];
    logic [SIDE_W-1:0] side_reg [QBITS];

    for (genvar i = 0; i < QBITS; i++)
    begin : g_step
        logic              vld_prev;
        logic [DIV_W-1:0]  rem_prev;
        logic [DIV_W-1:0]  div_prev;
        logic [QBITS-1:0]  quot_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [DIV_W:0]    r2;
        logic [DIV_W:0]    diff;
        logic              ge;
        logic [DIV_W-1:0]  rem_next;
        logic [QBITS-1:0]  quot_next;

        if (i == 0)
        begin : g_first
            assign vld_prev  = in_valid;
            assign rem_prev  = in_rem;
            assign div_prev  = in_div;
            assign quot_prev = '0;
            assign side_prev = in_side;
        end
        else
        begin : g_rest
            assign vld_prev  = vld_reg[i-1];
            assign rem_prev  = rem_reg[i-1];
            assign div_prev  = div_reg[i-1];
            assign quot_prev = quot_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        assign r2        = {rem_prev, 1'b0};
        assign diff      = r2 - {1'b0, div_prev};
        assign ge        = (r2 >= {1'b0, div_prev});
        assign rem_next  = ge ? diff[DIV_W-1:0] : r2[DIV_W-1:0];
        assign quot_next = {quot_prev[QBITS-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                div_reg[i]  <= div_prev;
                quot_reg[i] <= quot_next;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[QBITS-1];
    assign out_quot  = quot_reg[QBITS-1];
    assign out_side  = side_reg[QBITS-1];

endmodule

>>> design/tsw_back.sv
// ----------------------------------------------------------------------------
// tsw_back
// Gain multiply, rounding, clamping, sign and the output register. Also
// produces the pipeline advance enable.
// ----------------------------------------------------------------------------
module tsw_back
    import tsw_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    output logic                   en,
    input  logic                   in_valid,
    input  logic [G_BITS-1:0]      in_g,
    input  logic [SAMPLE_BITS-1:0] in_mag,
    input  logic                   in_neg,
    tsw_shaped_if.source           shaped
);

    localparam int PW = SAMPLE_BITS + G_BITS;
    localparam int YW = SAMPLE_BITS + 2;

    logic                   p_valid_reg;
    logic [PW-1:0]          p_reg;
    logic                   p_neg_reg;
    logic                   o_valid_reg;
    logic [SAMPLE_BITS-1:0] o_data_reg;

    logic [PW-1:0]          rounded;
    logic [YW-1:0]          y;
    logic [YW-1:0]          lim;
    logic [SAMPLE_BITS-1:0] y_sat;
    logic [SAMPLE_BITS-1:0] o_data_next;

    assign en = !o_valid_reg || shaped.ready;

    assign rounded     = p_reg + (PW'(1) << (FX_BITS - 1));
    assign y           = YW'(rounded >> FX_BITS);
    assign lim         = p_neg_reg ? (YW'(1) << (SAMPLE_BITS - 1))
                                   : ((YW'(1) << (SAMPLE_BITS - 1)) - YW'(1));
    assign y_sat       = (y > lim) ? lim[SAMPLE_BITS-1:0] : y[SAMPLE_BITS-1:0];
    assign o_data_next = p_neg_reg ? (~y_sat + SAMPLE_BITS'(1)) : y_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= in_valid;
            o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg      <= PW'(in_mag) * PW'(in_g);
            p_neg_reg  <= in_neg;
            o_data_reg <= o_data_next;
        end
    end

    assign shaped.valid      = o_valid_reg;
    assign shaped.shaped_out = o_data_reg;

endmodule

>>> design/scaled_tanh_waveshaper_top.sv
// ----------------------------------------------------------------------------
// scaled_tanh_waveshaper_top
// Soft clipper: shaped = (2/a) * tanh(a * sample / 2), computed as the
// sample times a continued-fraction approximation of tanh(v)/v.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  samples   in         sample_in, amount_in
//  shaped    out        shaped_out
//  cfg       in         index, data (register write)
//
// One sample is accepted per cycle unless stalled. Pipeline: three front
// stages, six 30-stage continued-fraction dividers, a 31-stage final divider
// and two output stages. Reset empties the pipeline and loads the registers.
// The whole pipeline holds while a result waits at the output unaccepted.
// ----------------------------------------------------------------------------
module scaled_tanh_waveshaper_top
    import tsw_pkg::*;
#(
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
    parameter int AMOUNT_FRAC_BITS = AMOUNT_FRAC_BITS_DEF
)(
    input  logic          clk,
    input  logic          rst_n,
    tsw_sample_if.sink    samples,
    tsw_shaped_if.source  shaped,
    tsw_cfg_if.sink       cfg
);

    localparam int CF_SIDE_W = FX_BITS + 1 + SAMPLE_BITS;
    localparam int G_SIDE_W  = 1 + SAMPLE_BITS;

    logic                   en;
    logic                   f_valid;
    logic [FX_BITS-1:0]     f_w;
    logic [SAMPLE_BITS-1:0] f_mag;
    logic                   f_neg;

    logic                   cf_valid [CF_DEPTH+1];
    logic [FX_BITS-1:0]     cf_t     [CF_DEPTH+1];
    logic [CF_SIDE_W-1:0]   cf_side  [CF_DEPTH+1];

    logic                   g_valid;
    logic [G_BITS-1:0]      g_quot;
    logic [G_SIDE_W-1:0]    g_side;

    tsw_front #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .AMOUNT_FRAC_BITS (AMOUNT_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .samples   (samples),
        .cfg       (cfg),
        .out_valid (f_valid),
        .out_w     (f_w),
        .out_mag   (f_mag),
        .out_neg   (f_neg)
    );

    assign cf_valid[0] = f_valid;
    assign cf_t[0]     = '0;
    assign cf_side[0]  = {f_w, f_neg, f_mag};

    for (genvar j = 0; j < CF_DEPTH; j++)
    begin : g_level
        localparam int K = CF_DEPTH - j;

        logic [CF_DIV_BITS-1:0] den;
        logic [CF_DIV_BITS-1:0] rem0;

        assign den  = (CF_DIV_BITS'(2 * K + 1) << FX_BITS) + CF_DIV_BITS'(cf_t[j]);
        assign rem0 = CF_DIV_BITS'(cf_side[j][CF_SIDE_W-1 -: FX_BITS]);

        tsw_div #(
            .QBITS  (FX_BITS),
            .DIV_W  (CF_DIV_BITS),
            .SIDE_W (CF_SIDE_W)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cf_valid[j]),
            .in_rem    (rem0),
            .in_div    (den),
            .in_side   (cf_side[j]),
            .out_valid (cf_valid[j+1]),
            .out_quot  (cf_t[j+1]),
            .out_side  (cf_side[j+1])
        );
    end

    tsw_div #(
        .QBITS  (G_BITS),
        .DIV_W  (G_BITS),
        .SIDE_W (G_SIDE_W)
    ) u_gain_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cf_valid[CF_DEPTH]),
        .in_rem    (G_BITS'(1) << (FX_BITS - 1)),
        .in_div    ((G_BITS'(1) << FX_BITS) + G_BITS'(cf_t[CF_DEPTH])),
        .in_side   (cf_side[CF_DEPTH][G_SIDE_W-1:0]),
        .out_valid (g_valid),
        .out_quot  (g_quot),
        .out_side  (g_side)
    );

    tsw_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (g_valid),
        .in_g     (g_quot),
        .in_mag   (g_side[SAMPLE_BITS-1:0]),
        .in_neg   (g_side[SAMPLE_BITS]),
        .shaped   (shaped)
    );

endmodule
